[hw/rtl/pending_packet_priority_queue_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the pending packet priority queue.
// Every macro samples on the rising edge of clk_i and is disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PENDING_PACKET_PRIORITY_QUEUE_MACROS_SVH
`define PENDING_PACKET_PRIORITY_QUEUE_MACROS_SVH

// The property must hold at every sampled edge.
`define PPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The expression must never be true at a sampled edge.
`define PPQ_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

[hw/rtl/ppq_pkg.sv]
// ----------------------------------------------------------------------------
// ppq_pkg
// Types, widths, codes and the ordering function shared by the queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ppq_pkg;

  localparam int unsigned PPQ_QUEUE_DEPTH = 16;

  localparam int unsigned PROP_W   = 31;
  localparam int unsigned SAMPLE_W = 30;
  localparam int unsigned JIT_W    = 31;
  localparam int unsigned DELAY_W  = 32;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned STATUS_W = 2;

  localparam logic [JIT_W-1:0] JITTER_MAX = {JIT_W{1'b1}};

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_POP    = 1'b1
  } ppq_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_POPPED   = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } ppq_status_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_JIT,
    CS_DELAY,
    CS_EXEC
  } ppq_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic calc_jit;
    logic calc_delay;
    logic exec;
  } ppq_cmd_t;

  // True when key a must leave strictly before key b.
  function automatic logic goes_before(
    input logic [DELAY_W-1:0] da,
    input logic               sa,
    input logic               ca,
    input logic [DELAY_W-1:0] db,
    input logic               sb,
    input logic               cb
  );
    logic res;
    if (da != db) begin
      res = (da < db);
    end else if (sa != sb) begin
      res = sa;
    end else begin
      res = ca & ~cb;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ppq_ctrl.sv]
// ----------------------------------------------------------------------------
// ppq_ctrl
// Sequencer for the queue: accepts a request, steps the datapath through the
// jitter and delay sums and the queue update, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pending_packet_priority_queue_macros.svh"

module ppq_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_kind_i,
  output logic                  in_ready_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output ppq_pkg::ppq_cmd_t     cmd_o
);
  import ppq_pkg::*;

  ppq_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_kind_i == KIND_POP) ? CS_EXEC : CS_JIT;
        end
      end
      CS_JIT: begin
        cmd_o.calc_jit = 1'b1;
        state_d        = CS_DELAY;
      end
      CS_DELAY: begin
        cmd_o.calc_delay = 1'b1;
        state_d          = CS_EXEC;
      end
      CS_EXEC: begin
        // The result register must be free or draining this cycle.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  `PPQ_ASSERT(a_exec_slot_free, cmd_o.exec |-> (!out_valid_q || out_ready_i), "exec with result slot busy")
  `PPQ_ASSERT(a_cmd_onehot, $onehot0({cmd_o.load, cmd_o.calc_jit, cmd_o.calc_delay, cmd_o.exec}), "commands overlap")
  `PPQ_ASSERT(a_insert_seq, (cmd_o.load && in_kind_i == KIND_INSERT) |=> cmd_o.calc_jit, "insert skipped jitter step")

endmodule

`default_nettype wire

[hw/rtl/ppq_datapath.sv]
// ----------------------------------------------------------------------------
// ppq_datapath
// Request registers, jitter and delay adders, the sorted row of queue cells
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pending_packet_priority_queue_macros.svh"

module ppq_datapath #(
  parameter int unsigned QUEUE_DEPTH = ppq_pkg::PPQ_QUEUE_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ppq_pkg::ppq_cmd_t             cmd_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [ppq_pkg::PROP_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_kind_i,
  input  wire logic                          in_channel_i,
  input  wire logic                          in_sender_is_slave_i,
  input  wire logic                          in_is_follow_up_i,
  input  wire logic [ppq_pkg::SAMPLE_W-1:0]  in_jitter_sample_i,
  output logic [ppq_pkg::STATUS_W-1:0]       out_status_o,
  output logic [ppq_pkg::DELAY_W-1:0]        out_head_delay_o,
  output logic                               out_head_to_slave_o,
  output logic                               out_head_channel_o,
  output logic [ppq_pkg::OCC_W-1:0]          out_occupancy_o
);
  import ppq_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

  // Captured request.
  logic                kind_q;
  logic                chan_q;
  logic                to_slave_q;
  logic                follow_q;
  logic [SAMPLE_W-1:0] sample_q;

  logic [PROP_W-1:0]   prop_q;
  logic [JIT_W-1:0]    prev_jit_q;
  logic [JIT_W-1:0]    jit_q, jit_d;
  logic [DELAY_W-1:0]  delay_q;
  logic [JIT_W:0]      jit_sum;

  logic [CNT_W-1:0]    count_q, count_d;
  logic                full, empty;

  // Queue cells, head at index zero.
  logic [DELAY_W-1:0]  e_delay_q [QUEUE_DEPTH];
  logic                e_slave_q [QUEUE_DEPTH];
  logic                e_chan_q  [QUEUE_DEPTH];

  logic [QUEUE_DEPTH-1:0] new_first;
  logic [QUEUE_DEPTH-1:0] take_new;

  // Result register.
  logic [STATUS_W-1:0] status_q;
  logic [DELAY_W-1:0]  hd_q;
  logic                hs_q;
  logic                hc_q;
  logic [OCC_W-1:0]    occ_q;

  assign full  = (count_q == FULL_COUNT);
  assign empty = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q     <= in_kind_i;
      chan_q     <= in_channel_i;
      to_slave_q <= ~in_sender_is_slave_i;
      follow_q   <= in_is_follow_up_i;
      sample_q   <= in_jitter_sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q <= '0;
    end else if (cfg_we_i) begin
      prop_q <= cfg_wdata_i;
    end
  end

  // Follow-up jitter chains saturate at the largest 31-bit value.
  assign jit_sum = {{(JIT_W + 1 - SAMPLE_W){1'b0}}, sample_q}
                 + {1'b0, (follow_q ? prev_jit_q : {JIT_W{1'b0}})};
  assign jit_d   = jit_sum[JIT_W] ? JITTER_MAX : jit_sum[JIT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_jit) begin
      jit_q <= jit_d;
    end
    if (cmd_i.calc_delay) begin
      delay_q <= {1'b0, prop_q} + {1'b0, jit_q};
    end
  end

  // Each cell compares the new key with its own entry; the result is a run
  // of ones between the insertion point and the fill level.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      new_first[i] = (CNT_W'(i) < count_q)
                   & goes_before(delay_q, to_slave_q, chan_q,
                                 e_delay_q[i], e_slave_q[i], e_chan_q[i]);
    end
    take_new[0] = new_first[0] | empty;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      take_new[i] = ~new_first[i-1] & (new_first[i] | (CNT_W'(i) == count_q));
    end
  end

  always_comb begin
    count_d = count_q;
    if (kind_q == KIND_POP) begin
      if (!empty) begin
        count_d = count_q - 1'b1;
      end
    end else if (!full) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      prev_jit_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
      if (kind_q == KIND_INSERT && !full) begin
        prev_jit_q <= jit_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (kind_q == KIND_POP) begin
        if (!empty) begin
          for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            e_delay_q[i] <= e_delay_q[i+1];
            e_slave_q[i] <= e_slave_q[i+1];
            e_chan_q[i]  <= e_chan_q[i+1];
          end
        end
      end else if (!full) begin
        if (take_new[0]) begin
          e_delay_q[0] <= delay_q;
          e_slave_q[0] <= to_slave_q;
          e_chan_q[0]  <= chan_q;
        end
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
          if (new_first[i-1]) begin
            e_delay_q[i] <= e_delay_q[i-1];
            e_slave_q[i] <= e_slave_q[i-1];
            e_chan_q[i]  <= e_chan_q[i-1];
          end else if (take_new[i]) begin
            e_delay_q[i] <= delay_q;
            e_slave_q[i] <= to_slave_q;
            e_chan_q[i]  <= chan_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      hd_q  <= '0;
      hs_q  <= 1'b0;
      hc_q  <= 1'b0;
      occ_q <= OCC_W'(count_d);
      if (kind_q == KIND_POP) begin
        if (empty) begin
          status_q <= ST_EMPTY;
        end else begin
          status_q <= ST_POPPED;
          hd_q     <= e_delay_q[0];
          hs_q     <= e_slave_q[0];
          hc_q     <= e_chan_q[0];
        end
      end else begin
        status_q <= full ? ST_FULL : ST_INSERTED;
      end
    end
  end

  assign out_status_o        = status_q;
  assign out_head_delay_o    = hd_q;
  assign out_head_to_slave_o = hs_q;
  assign out_head_channel_o  = hc_q;
  assign out_occupancy_o     = occ_q;

  `PPQ_ASSERT_NEVER(a_count_range, count_q > FULL_COUNT, "entry count beyond depth")
  `PPQ_ASSERT(a_pop_dec,
    (cmd_i.exec && kind_q == KIND_POP && count_q != '0)
      |=> (count_q == $past(count_q) - 1'b1),
    "pop did not remove one entry")
  `PPQ_ASSERT_NEVER(a_head_order,
    (count_q >= CNT_W'(2)) && goes_before(e_delay_q[1], e_slave_q[1], e_chan_q[1],
                                          e_delay_q[0], e_slave_q[0], e_chan_q[0]),
    "head cells out of order")

endmodule

`default_nettype wire

[hw/rtl/pending_packet_priority_queue.sv]
// ----------------------------------------------------------------------------
// pending_packet_priority_queue
// Sorted queue of pending simulated packets, ordered by delivery delay.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel. tuser selects an insert (0) or a pop
// (1); tdata carries the channel, sender role, follow-up flag and jitter
// sample. Every request produces exactly one result on the m_axis channel:
// a status in tuser, and in tdata the popped entry (zero when nothing is
// popped) and the occupancy after the request.
// The propagation delay register is written through cfg_we_i/cfg_wdata_i and
// must only be changed while no request is in flight.
// A pop captures the request and then updates the queue. An insert captures
// the request, forms the jitter sum and then the delay sum, and then the row
// of queue cells compares the new key and shifts in place.
// The sequencer handles one request at a time: it takes no new request until
// the last one has written its result.
// The result sits in an output register, so the next request is accepted
// while it waits; a stalled receiver only blocks the queue update step.
// Reset empties the queue and clears the remembered jitter and the
// propagation delay. Cell contents are not cleared, since only entries below
// the fill count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module pending_packet_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = ppq_pkg::PPQ_QUEUE_DEPTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Configuration: propagation delay in nanoseconds.
  input  wire logic                        cfg_we_i,
  input  wire logic [ppq_pkg::PROP_W-1:0]  cfg_wdata_i,
  // Request channel.
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata from bit 0: channel, sender_is_slave, is_follow_up,
  // jitter_sample[29:0], seven zero bits.
  input  wire logic [39:0]                 s_axis_tdata,
  // tuser: kind.
  input  wire logic                        s_axis_tuser,
  // Result channel.
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // tdata from bit 0: head_delay[31:0], head_to_slave, head_channel,
  // occupancy[4:0], one zero bit.
  output logic [39:0]                      m_axis_tdata,
  // tuser: status[1:0].
  output logic [ppq_pkg::STATUS_W-1:0]     m_axis_tuser
);
  import ppq_pkg::*;

  ppq_cmd_t            cmd;
  logic [DELAY_W-1:0]  head_delay;
  logic                head_to_slave;
  logic                head_channel;
  logic [OCC_W-1:0]    occupancy;

  // The sequencer decides when each datapath step runs and owns the
  // handshakes on both channels.
  ppq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_kind_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  // The datapath holds the queue cells, the remembered jitter and the result.
  ppq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_kind_i            (s_axis_tuser),
    .in_channel_i         (s_axis_tdata[0]),
    .in_sender_is_slave_i (s_axis_tdata[1]),
    .in_is_follow_up_i    (s_axis_tdata[2]),
    .in_jitter_sample_i   (s_axis_tdata[32:3]),
    .out_status_o         (m_axis_tuser),
    .out_head_delay_o     (head_delay),
    .out_head_to_slave_o  (head_to_slave),
    .out_head_channel_o   (head_channel),
    .out_occupancy_o      (occupancy)
  );

  assign m_axis_tdata = {1'b0, occupancy, head_channel, head_to_slave, head_delay};

endmodule

`default_nettype wire

[test/tb_pending_packet_priority_queue.sv]
// ----------------------------------------------------------------------------
// tb_pending_packet_priority_queue
// Self-checking bench for the sorted queue of pending simulated packets.
// ----------------------------------------------------------------------------
// Requests reach the block over its slave-side stream. The bench keeps its
// own sorted packet list, the remembered jitter and the propagation delay.
// From these it works out the one result that every accepted request causes.
// Results that arrive on the master-side stream are compared field by field
// with the oldest outstanding prediction.
// The run opens with a directed sequence. It covers a pop of an empty queue,
// the ordering on equal delays, first in first out among equal keys, jitter
// saturation through chained follow-ups, the largest delay, and an insert
// into a full queue. Random phases follow, each with its own propagation
// delay, under three patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pending_packet_priority_queue;

  import ppq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = PPQ_QUEUE_DEPTH;
  localparam logic [31:0] JITTER_CEIL = 32'h7FFF_FFFF;
  localparam logic [30:0] LINK_DELAY_MAX = 31'h7FFF_FFFF;
  localparam logic [29:0] SAMPLE_MAX = 30'h3FFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned MAX_REPORTS = 10;

  // One request as the sender sees it.
  typedef struct packed {
    ppq_kind_e   kind;
    logic        channel;
    logic        sender_is_slave;
    logic        is_follow_up;
    logic [29:0] jitter_sample;
  } request_t;

  // One result as it leaves the block.
  typedef struct packed {
    ppq_status_e status;
    logic [31:0] head_delay;
    logic        head_to_slave;
    logic        head_channel;
    logic [4:0]  occupancy;
  } outcome_t;

  // One packet held in the sorted list.
  typedef struct packed {
    logic [31:0] delay;
    logic        to_slave;
    logic        channel;
  } packet_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [30:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // Requests waiting for the driver, and predicted results in order.
  request_t    request_queue[$];
  outcome_t    outcome_q[$];

  // The bench's own view of the block's state.
  packet_t     held_packets[$];
  logic [30:0] last_jitter = '0;
  logic [30:0] link_delay = '0;

  // Handshake seen at the last rising edge on the request side.
  logic        req_fire = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  pending_packet_priority_queue i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // A packet leaves strictly earlier when its key is smaller. The key puts a
  // smaller delay first, then a packet for the slave, then the higher
  // channel. Equal keys never overtake, so the list stays first in, first
  // out among them.
  function automatic logic leaves_first(input packet_t a, input packet_t b);
    return {a.delay, ~a.to_slave, ~a.channel} < {b.delay, ~b.to_slave, ~b.channel};
  endfunction

  // Applies one accepted request to the bench's state and returns the result
  // that the block has to produce for it.
  function automatic outcome_t apply_request(input request_t r);
    outcome_t    o;
    packet_t     pkt;
    logic [31:0] jit;
    int          pos;
    o = '0;
    if (r.kind == KIND_INSERT) begin
      if (held_packets.size() >= QUEUE_DEPTH) begin
        // A dropped insert leaves everything alone, the jitter included.
        o.status = ST_FULL;
      end else begin
        jit = {2'b00, r.jitter_sample};
        if (r.is_follow_up) begin
          jit = jit + {1'b0, last_jitter};
        end
        if (jit > JITTER_CEIL) begin
          jit = JITTER_CEIL;
        end
        last_jitter = jit[30:0];
        pkt.delay = {1'b0, link_delay} + jit;
        pkt.to_slave = ~r.sender_is_slave;
        pkt.channel = r.channel;
        pos = held_packets.size();
        while (pos > 0 && leaves_first(pkt, held_packets[pos-1])) begin
          pos--;
        end
        held_packets.insert(pos, pkt);
        o.status = ST_INSERTED;
      end
    end else if (held_packets.size() == 0) begin
      o.status = ST_EMPTY;
    end else begin
      pkt = held_packets.pop_front();
      o.status = ST_POPPED;
      o.head_delay = pkt.delay;
      o.head_to_slave = pkt.to_slave;
      o.head_channel = pkt.channel;
    end
    o.occupancy = 5'(held_packets.size());
    return o;
  endfunction

  function automatic request_t make_req(input ppq_kind_e kind, input logic channel,
                                        input logic sender_is_slave,
                                        input logic is_follow_up,
                                        input logic [29:0] jitter_sample);
    request_t r;
    r.kind = kind;
    r.channel = channel;
    r.sender_is_slave = sender_is_slave;
    r.is_follow_up = is_follow_up;
    r.jitter_sample = jitter_sample;
    return r;
  endfunction

  // Request driver. A request stays on the bus until it has been taken; a
  // fresh one is only offered when the sender does not idle this cycle.
  always @(negedge clk_i) begin : request_driver
    request_t r;
    if (rst_ni) begin
      if (s_axis_tvalid && !req_fire) begin
        // Hold the current request.
      end else if (request_queue.size() != 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        r = request_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, r.jitter_sample, r.is_follow_up,
                          r.sender_is_slave, r.channel};
        s_axis_tuser  <= r.kind;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor. Every handshake is sampled at the rising edge: an accepted
  // request is turned into a prediction, and an accepted result is checked
  // against the oldest prediction.
  always @(posedge clk_i) begin : result_monitor
    request_t taken;
    outcome_t seen;
    outcome_t want;
    req_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (cfg_we_i) begin
        link_delay = cfg_wdata_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.status        = ppq_status_e'(m_axis_tuser);
        seen.head_delay    = m_axis_tdata[31:0];
        seen.head_to_slave = m_axis_tdata[32];
        seen.head_channel  = m_axis_tdata[33];
        seen.occupancy     = m_axis_tdata[38:34];
        if (outcome_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected result: status %0d delay %h to_slave %b channel %b occ %0d",
                     seen.status, seen.head_delay, seen.head_to_slave,
                     seen.head_channel, seen.occupancy);
          end
        end else begin
          want = outcome_q.pop_front();
          if (seen.status != want.status || seen.head_delay != want.head_delay ||
              seen.head_to_slave != want.head_to_slave ||
              seen.head_channel != want.head_channel ||
              seen.occupancy != want.occupancy) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("result differs at cycle %0d", cycle_count);
              $display("  expected: status %0d delay %h to_slave %b channel %b occ %0d",
                       want.status, want.head_delay, want.head_to_slave,
                       want.head_channel, want.occupancy);
              $display("  actual:   status %0d delay %h to_slave %b channel %b occ %0d",
                       seen.status, seen.head_delay, seen.head_to_slave,
                       seen.head_channel, seen.occupancy);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        taken = make_req(ppq_kind_e'(s_axis_tuser), s_axis_tdata[0], s_axis_tdata[1],
                         s_axis_tdata[2], s_axis_tdata[32:3]);
        outcome_q.push_back(apply_request(taken));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pending_packet_priority_queue: mismatch");
      $finish;
    end
  end

  // The propagation delay is only written once the block has gone quiet.
  task automatic write_link_delay(input logic [30:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Holds the sender back until every request has gone and every result has
  // come, then lets the block settle. The check runs at the rising edge, where
  // the driver's last update has settled.
  task automatic drain;
    while (request_queue.size() != 0 || s_axis_tvalid || outcome_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(negedge clk_i);
  endtask

  task automatic add_directed_requests;
    // Pop of an empty queue.
    request_queue.push_back(make_req(KIND_POP, 1'b0, 1'b0, 1'b0, '0));
    // Equal delays: the higher channel overtakes, a packet for the master
    // queues behind, and a fully equal key goes behind its twin.
    request_queue.push_back(make_req(KIND_INSERT, 1'b0, 1'b0, 1'b0, 30'd5));
    request_queue.push_back(make_req(KIND_INSERT, 1'b1, 1'b0, 1'b0, 30'd5));
    request_queue.push_back(make_req(KIND_INSERT, 1'b0, 1'b1, 1'b0, 30'd5));
    request_queue.push_back(make_req(KIND_INSERT, 1'b0, 1'b0, 1'b0, 30'd5));
    // Chained follow-ups with the largest sample run the jitter into its
    // ceiling, which with the largest link delay gives the largest delay.
    request_queue.push_back(make_req(KIND_INSERT, 1'b1, 1'b1, 1'b1, SAMPLE_MAX));
    request_queue.push_back(make_req(KIND_INSERT, 1'b0, 1'b0, 1'b1, SAMPLE_MAX));
    request_queue.push_back(make_req(KIND_INSERT, 1'b1, 1'b0, 1'b1, SAMPLE_MAX));
    // Zero jitter for both destinations, then the largest sample for the master.
    request_queue.push_back(make_req(KIND_INSERT, 1'b1, 1'b1, 1'b0, '0));
    request_queue.push_back(make_req(KIND_INSERT, 1'b1, 1'b0, 1'b0, '0));
    request_queue.push_back(make_req(KIND_INSERT, 1'b0, 1'b1, 1'b0, SAMPLE_MAX));
    for (int i = 0; i < 6; i++) begin
      request_queue.push_back(make_req(KIND_INSERT, 1'($urandom), 1'($urandom),
                                       1'b0, 30'(i)));
    end
    // The queue is now full. The dropped follow-up must not touch the
    // remembered jitter, which the next follow-up then shows.
    request_queue.push_back(make_req(KIND_INSERT, 1'b1, 1'b1, 1'b1, SAMPLE_MAX));
    request_queue.push_back(make_req(KIND_POP, 1'b0, 1'b0, 1'b0, '0));
    request_queue.push_back(make_req(KIND_INSERT, 1'b0, 1'b1, 1'b1, 30'd1));
    repeat (5) request_queue.push_back(make_req(KIND_POP, 1'b1, 1'b1, 1'b1, SAMPLE_MAX));
  endtask

  // Random requests in bursts of sixteen, each burst leaning towards
  // inserts, pops or neither, so that the queue fills up and runs dry.
  task automatic add_random_requests(input int unsigned count);
    int unsigned insert_pct;
    int unsigned pick;
    logic [29:0] sample;
    insert_pct = 50;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 16 == 0) begin
        case ($urandom_range(2))
          0: begin
            insert_pct = 85;
          end
          1: begin
            insert_pct = 50;
          end
          default: begin
            insert_pct = 15;
          end
        endcase
      end
      // Small samples give equal delays, large ones drive follow-up chains
      // towards saturation.
      pick = $urandom_range(99);
      if (pick < 40) begin
        sample = 30'($urandom_range(7));
      end else if (pick < 60) begin
        sample = SAMPLE_MAX - 30'($urandom_range(7));
      end else begin
        sample = 30'($urandom);
      end
      request_queue.push_back(make_req(
          ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_POP,
          1'($urandom), 1'($urandom), $urandom_range(99) < 40, sample));
    end
  endtask

  initial begin : stimulus
    logic [30:0] delay_plan[6];
    delay_plan[0] = '0;
    delay_plan[1] = 31'($urandom);
    delay_plan[2] = 31'($urandom_range(40, 1));
    delay_plan[3] = LINK_DELAY_MAX;
    delay_plan[4] = 31'($urandom);
    delay_plan[5] = '0;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct  = 15;
    recv_stall_pct = 57;
    write_link_delay(LINK_DELAY_MAX);
    add_directed_requests();
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct  = 57;
        recv_stall_pct = 15;
      end else if (p == 4) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      write_link_delay(delay_plan[p]);
      add_random_requests(142);
      drain();
    end

    if (mismatch_count == 0 && outcome_q.size() == 0) begin
      $display("pending_packet_priority_queue: match");
    end else begin
      $display("pending_packet_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
